// ----- rtl/jacobi_pressure_solver_assert.svh -----
// Assertion macros for the Jacobi pressure solver top level.
// Expects aclk and aresetn in scope where a macro is used.
`ifndef JACOBI_PRESSURE_SOLVER_ASSERT_SVH
`define JACOBI_PRESSURE_SOLVER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define JPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define JPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/jps_pkg.sv -----
// Shared constants, types and functions of the Jacobi pressure solver.
// No dependencies; used by jps_alu and jacobi_pressure_solver.
`timescale 1ns / 1ps

package jps_pkg;

    localparam int MAX_GRID  = 64;
    localparam int FRAC_BITS = 16;

    localparam int IDX_W  = $clog2(MAX_GRID);
    localparam int ADDR_W = 2 * IDX_W;
    localparam int CNT_W  = $clog2(MAX_GRID + 1);
    localparam int DATA_W = 32;
    localparam int PROD_W = 2 * DATA_W;
    localparam int RND_W  = PROD_W - FRAC_BITS;

    localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) <<< (FRAC_BITS - 1);

    // Command codes carried in s_tuser.
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_SOLVE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_GRID_SIZE   = 2'd0;
    localparam logic [1:0] REG_ALPHA_GAIN  = 2'd1;
    localparam logic [1:0] REG_RBETA_GAIN  = 2'd2;
    localparam logic [1:0] REG_SWEEP_COUNT = 2'd3;

    localparam logic [6:0]               GRID_RESET  = 7'd64;
    localparam logic signed [DATA_W-1:0] ALPHA_RESET = -32'sd65536;
    localparam logic signed [DATA_W-1:0] RBETA_RESET = 32'sd16384;
    localparam logic [9:0]               SWEEP_RESET = 10'd100;

    // Multiplier operand select.
    localparam logic MUL_ALPHA_DIV = 1'b0;
    localparam logic MUL_ACC_RBETA = 1'b1;

    typedef struct packed {
        logic mul_en;   // load product register
        logic mul_sel;  // operand pair
        logic acc_en;   // update accumulator
        logic acc_load; // start a new sum
        logic acc_rnd;  // add rounded product instead of memory data
    } alu_ctrl_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [RND_W-1:0] v);
        logic [RND_W-DATA_W:0] hi;
        hi = v[RND_W-1:DATA_W-1];
        if (hi == '0 || hi == '1) begin
            return v[DATA_W-1:0];
        end else if (v[RND_W-1]) begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end
    endfunction

endpackage

// ----- rtl/jps_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module jps_ram #(
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 12
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [0:(1 << ADDR_W) - 1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/jps_alu.sv -----
// Shared arithmetic unit: one 32x32 multiplier, rounding stage, accumulator
// and output saturation. Depends on jps_pkg.
`timescale 1ns / 1ps

module jps_alu (
    input  logic                              aclk,
    input  jps_pkg::alu_ctrl_t                ctrl,
    input  logic signed [jps_pkg::DATA_W-1:0] alpha_gain,
    input  logic signed [jps_pkg::DATA_W-1:0] rbeta_gain,
    input  logic signed [jps_pkg::DATA_W-1:0] div_data,
    input  logic signed [jps_pkg::DATA_W-1:0] src_data,
    output logic signed [jps_pkg::DATA_W-1:0] result
);

    logic signed [jps_pkg::DATA_W-1:0] mul_a;
    logic signed [jps_pkg::DATA_W-1:0] mul_b;
    logic signed [jps_pkg::DATA_W-1:0] acc_sat;
    logic signed [jps_pkg::PROD_W-1:0] prod_next;
    logic signed [jps_pkg::PROD_W-1:0] prod_reg;
    logic signed [jps_pkg::PROD_W-1:0] rnd_sum;
    logic signed [jps_pkg::RND_W-1:0]  rnd_reg;
    logic signed [jps_pkg::RND_W-1:0]  addend;
    logic signed [jps_pkg::RND_W-1:0]  acc_reg;

    assign acc_sat = jps_pkg::sat32(acc_reg);
    assign mul_a   = (ctrl.mul_sel == jps_pkg::MUL_ACC_RBETA) ? acc_sat : alpha_gain;
    assign mul_b   = (ctrl.mul_sel == jps_pkg::MUL_ACC_RBETA) ? rbeta_gain : div_data;
    assign prod_next = mul_a * mul_b;

    // Round half up: add half an LSB, then floor through the arithmetic shift.
    assign rnd_sum = prod_reg + jps_pkg::RND_HALF;

    assign addend = ctrl.acc_rnd ? rnd_reg
                  : {{(jps_pkg::RND_W-jps_pkg::DATA_W){src_data[jps_pkg::DATA_W-1]}}, src_data};

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= prod_next;
        end
        rnd_reg <= rnd_sum[jps_pkg::PROD_W-1:jps_pkg::FRAC_BITS];
        if (ctrl.acc_en) begin
            acc_reg <= (ctrl.acc_load ? '0 : acc_reg) + addend;
        end
    end

    assign result = jps_pkg::sat32(rnd_reg);

endmodule

// ----- rtl/jacobi_pressure_solver.sv -----
// Top level of the Jacobi pressure solver: command handshake, configuration,
// sequencer and stores. Depends on jps_pkg, jps_ram, jps_alu and the assert header.
`timescale 1ns / 1ps
`include "jacobi_pressure_solver_assert.svh"

// Usage
//   Input stream (s_*): s_tuser carries the command (load, solve, read), s_tdata the
//   cell column, row and divergence value. Each accepted beat gives exactly one
//   result beat on the output stream (m_*): m_tdata the pressure, m_tuser the status.
//   Configuration: cfg_we, cfg_addr, cfg_wdata write one register per cycle; write
//   only while the block is idle.
// Sequencing
//   Load, unused command or bad index: the response state follows acceptance, and
//   m_tvalid rises once the output register is free. Read: a registered memory read
//   comes first. s_tready returns with m_tvalid. Solve: a clearing pass over all 4096
//   words of the ping store, then the sweeps, each cell taking states C0 to C8, a
//   schedule set by the single read port of the source store (four neighbor reads per
//   cell) and the one shared multiplier used twice per cell, then the response state.
//   s_tready is high only when no command is in progress: one command at a time.
// Reset
//   Config and sequencer registers go to defaults; the output goes empty. Divergence and
//   pressure stores are not cleared; read only cells that were loaded or solved.
// Stall
//   A result holds in the output register until taken; the next command is
//   accepted and worked meanwhile, and its result waits until the register frees.

module jacobi_pressure_solver (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // cell_x[6:0], cell_y[13:7], div_value[45:14], zero
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // pressure_value[31:0]
    output logic        m_tuser,   // status[0]
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);

    localparam int IDX_W  = jps_pkg::IDX_W;
    localparam int ADDR_W = jps_pkg::ADDR_W;
    localparam int CNT_W  = jps_pkg::CNT_W;
    localparam int DW     = jps_pkg::DATA_W;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CLEAR = 4'd1;
    localparam logic [3:0] ST_C0    = 4'd2;   // read left, divergence
    localparam logic [3:0] ST_C1    = 4'd3;   // read right, start alpha*div
    localparam logic [3:0] ST_C2    = 4'd4;   // read bottom
    localparam logic [3:0] ST_C3    = 4'd5;   // read top
    localparam logic [3:0] ST_C4    = 4'd6;   // add top
    localparam logic [3:0] ST_C5    = 4'd7;   // add rounded divergence term
    localparam logic [3:0] ST_C6    = 4'd8;   // start sum*rbeta
    localparam logic [3:0] ST_C7    = 4'd9;   // round
    localparam logic [3:0] ST_C8    = 4'd10;  // write cell, advance
    localparam logic [3:0] ST_READ  = 4'd11;
    localparam logic [3:0] ST_RESP  = 4'd12;

    // configuration registers
    logic [6:0]           grid_size_reg;
    logic signed [DW-1:0] alpha_reg;
    logic signed [DW-1:0] rbeta_reg;
    logic [9:0]           sweep_reg;

    // sequencer state
    logic [3:0]        state_reg;
    logic [IDX_W-1:0]  i_reg;
    logic [IDX_W-1:0]  j_reg;
    logic [9:0]        k_reg;
    logic [ADDR_W-1:0] clr_reg;
    logic              lat_reg;   // 0: ping holds the latest sweep
    logic [DW-1:0]     res_pv_reg;
    logic              res_st_reg;

    // output register
    logic          m_tvalid_reg;
    logic [DW-1:0] m_pv_reg;
    logic          m_st_reg;

    // input beat fields
    logic [1:0]    in_cmd;
    logic [6:0]    in_x;
    logic [6:0]    in_y;
    logic [DW-1:0] in_div;
    logic          in_ok;
    logic          accept;
    logic [ADDR_W-1:0] in_addr;

    logic [CNT_W-1:0] n_eff;
    logic [IDX_W-1:0] n_last;
    logic [IDX_W-1:0] i_dn, i_up, j_dn, j_up;
    logic [ADDR_W-1:0] cell_addr;
    logic [ADDR_W-1:0] nb_addr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [ADDR_W-1:0] wr_addr;
    logic [DW-1:0]     wr_data;
    logic              ping_we;
    logic              pong_we;
    logic              div_we;
    logic [DW-1:0]     ping_rdata;
    logic [DW-1:0]     pong_rdata;
    logic [DW-1:0]     div_rdata;
    logic [DW-1:0]     src_rdata;
    logic signed [DW-1:0] alu_result;
    jps_pkg::alu_ctrl_t alu_ctrl;
    logic              out_free;
    logic              in_sweep;

    assign in_cmd = s_tuser;
    assign in_x   = s_tdata[6:0];
    assign in_y   = s_tdata[13:7];
    assign in_div = s_tdata[45:14];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Clamp the grid size to 2..MAX_GRID.
    always_comb begin
        if (grid_size_reg < 7'd2) begin
            n_eff = CNT_W'(2);
        end else if (int'(grid_size_reg) > jps_pkg::MAX_GRID) begin
            n_eff = CNT_W'(jps_pkg::MAX_GRID);
        end else begin
            n_eff = CNT_W'(grid_size_reg);
        end
    end
    assign n_last = IDX_W'(n_eff - CNT_W'(1));

    assign in_ok = (in_x != 7'd0) && (int'(in_x) <= int'(n_eff))
                && (in_y != 7'd0) && (int'(in_y) <= int'(n_eff));
    assign in_addr = {IDX_W'(in_y - 7'd1), IDX_W'(in_x - 7'd1)};

    // Border neighbors fold back onto the center cell.
    assign i_dn = (i_reg == '0)     ? i_reg : i_reg - IDX_W'(1);
    assign i_up = (i_reg == n_last) ? i_reg : i_reg + IDX_W'(1);
    assign j_dn = (j_reg == '0)     ? j_reg : j_reg - IDX_W'(1);
    assign j_up = (j_reg == n_last) ? j_reg : j_reg + IDX_W'(1);
    assign cell_addr = {j_reg, i_reg};

    always_comb begin
        unique case (state_reg)
            ST_C0:   nb_addr = {j_reg, i_dn};
            ST_C1:   nb_addr = {j_reg, i_up};
            ST_C2:   nb_addr = {j_dn, i_reg};
            ST_C3:   nb_addr = {j_up, i_reg};
            default: nb_addr = cell_addr;
        endcase
    end

    assign ram_raddr = (state_reg == ST_IDLE) ? in_addr : nb_addr;
    assign wr_addr   = (state_reg == ST_CLEAR) ? clr_reg : cell_addr;
    assign wr_data   = (state_reg == ST_CLEAR) ? '0 : alu_result;
    assign ping_we   = (state_reg == ST_CLEAR) || ((state_reg == ST_C8) && lat_reg);
    assign pong_we   = (state_reg == ST_C8) && !lat_reg;
    assign div_we    = accept && (in_cmd == jps_pkg::CMD_LOAD) && in_ok;
    assign src_rdata = lat_reg ? pong_rdata : ping_rdata;
    assign in_sweep  = (state_reg >= ST_C0) && (state_reg <= ST_C8);

    jps_ram #(.WIDTH(DW), .ADDR_W(ADDR_W)) u_div_ram (
        .aclk  (aclk),
        .we    (div_we),
        .waddr (in_addr),
        .wdata (in_div),
        .raddr (cell_addr),
        .rdata (div_rdata)
    );

    jps_ram #(.WIDTH(DW), .ADDR_W(ADDR_W)) u_ping_ram (
        .aclk  (aclk),
        .we    (ping_we),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (ram_raddr),
        .rdata (ping_rdata)
    );

    jps_ram #(.WIDTH(DW), .ADDR_W(ADDR_W)) u_pong_ram (
        .aclk  (aclk),
        .we    (pong_we),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (ram_raddr),
        .rdata (pong_rdata)
    );

    // Steer the shared unit through the per-cell schedule.
    always_comb begin
        alu_ctrl = '0;
        alu_ctrl.mul_sel = jps_pkg::MUL_ALPHA_DIV;
        unique case (state_reg) inside
            ST_C1: begin
                alu_ctrl.mul_en   = 1'b1;
                alu_ctrl.acc_en   = 1'b1;
                alu_ctrl.acc_load = 1'b1;
            end
            ST_C2, ST_C3, ST_C4: begin
                alu_ctrl.acc_en = 1'b1;
            end
            ST_C5: begin
                alu_ctrl.acc_en  = 1'b1;
                alu_ctrl.acc_rnd = 1'b1;
            end
            ST_C6: begin
                alu_ctrl.mul_en  = 1'b1;
                alu_ctrl.mul_sel = jps_pkg::MUL_ACC_RBETA;
            end
            default: begin
                alu_ctrl = '0;
            end
        endcase
    end

    jps_alu u_alu (
        .aclk       (aclk),
        .ctrl       (alu_ctrl),
        .alpha_gain (alpha_reg),
        .rbeta_gain (rbeta_reg),
        .div_data   (div_rdata),
        .src_data   (src_rdata),
        .result     (alu_result)
    );

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_size_reg <= jps_pkg::GRID_RESET;
            alpha_reg     <= jps_pkg::ALPHA_RESET;
            rbeta_reg     <= jps_pkg::RBETA_RESET;
            sweep_reg     <= jps_pkg::SWEEP_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                jps_pkg::REG_GRID_SIZE:   grid_size_reg <= cfg_wdata[6:0];
                jps_pkg::REG_ALPHA_GAIN:  alpha_reg     <= cfg_wdata;
                jps_pkg::REG_RBETA_GAIN:  rbeta_reg     <= cfg_wdata;
                jps_pkg::REG_SWEEP_COUNT: sweep_reg     <= cfg_wdata[9:0];
            endcase
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    // Sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            lat_reg   <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            clr_reg   <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        res_pv_reg <= '0;
                        res_st_reg <= ((in_cmd == jps_pkg::CMD_LOAD) ||
                                       (in_cmd == jps_pkg::CMD_READ)) && !in_ok;
                        unique case (in_cmd)
                            jps_pkg::CMD_SOLVE: begin
                                lat_reg   <= 1'b0;
                                i_reg     <= '0;
                                j_reg     <= '0;
                                k_reg     <= '0;
                                clr_reg   <= '0;
                                state_reg <= ST_CLEAR;
                            end
                            jps_pkg::CMD_READ: begin
                                state_reg <= in_ok ? ST_READ : ST_RESP;
                            end
                            default: begin
                                state_reg <= ST_RESP;
                            end
                        endcase
                    end
                end
                ST_CLEAR: begin
                    clr_reg <= clr_reg + ADDR_W'(1);
                    if (clr_reg == '1) begin
                        state_reg <= (sweep_reg == '0) ? ST_RESP : ST_C0;
                    end
                end
                ST_C0: state_reg <= ST_C1;
                ST_C1: state_reg <= ST_C2;
                ST_C2: state_reg <= ST_C3;
                ST_C3: state_reg <= ST_C4;
                ST_C4: state_reg <= ST_C5;
                ST_C5: state_reg <= ST_C6;
                ST_C6: state_reg <= ST_C7;
                ST_C7: state_reg <= ST_C8;
                ST_C8: begin
                    state_reg <= ST_C0;
                    if (i_reg == n_last) begin
                        i_reg <= '0;
                        if (j_reg == n_last) begin
                            // sweep done: swap stores
                            j_reg   <= '0;
                            lat_reg <= !lat_reg;
                            k_reg   <= k_reg + 10'd1;
                            if (k_reg + 10'd1 == sweep_reg) begin
                                state_reg <= ST_RESP;
                            end
                        end else begin
                            j_reg <= j_reg + IDX_W'(1);
                        end
                    end else begin
                        i_reg <= i_reg + IDX_W'(1);
                    end
                end
                ST_READ: begin
                    res_pv_reg <= lat_reg ? pong_rdata : ping_rdata;
                    state_reg  <= ST_RESP;
                end
                ST_RESP: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Output register: load from the response state, drop when taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if ((state_reg == ST_RESP) && out_free) begin
            m_tvalid_reg <= 1'b1;
            m_pv_reg     <= res_pv_reg;
            m_st_reg     <= res_st_reg;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_pv_reg;
    assign m_tuser  = m_st_reg;

    // A solve always starts with the clearing pass and ping as the latest store.
    `JPS_ASSERT_NEXT(a_solve_clears, accept && (in_cmd == jps_pkg::CMD_SOLVE), (state_reg == ST_CLEAR) && !lat_reg, "solve did not start the clearing pass")
    // The cell walk never leaves the grid in use.
    `JPS_ASSERT_NOW(a_cell_in_grid, in_sweep, (i_reg <= n_last) && (j_reg <= n_last), "cell counter outside the grid")
    // Results enter the output register only from the response state.
    `JPS_ASSERT_NOW(a_resp_source, $rose(m_tvalid_reg), $past(state_reg) == ST_RESP, "result beat raised outside the response state")

endmodule
